[hw/rtl/ccg_pkg.sv]
// Shared types and constants for the charset candidate generator.
// Used by ccg_cell, charset_candidate_generator_core and the bench; no dependencies.
`default_nettype none

package ccg_pkg;

  localparam int CHAR_W            = 8;
  localparam int TBL_DEPTH         = 32;
  localparam int POS_W             = 5;
  localparam int IDX_W_MAX         = 8;
  localparam int LEN_W_MAX         = 7;
  localparam int OUT_LEN_W         = 6;
  localparam int MODE_W            = 3;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 7;
  localparam int DEF_MAX_LEN       = 32;
  localparam int DEF_CHARSET_DEPTH = 64;

  // Command codes carried in in_mode
  localparam logic [MODE_W-1:0] MODE_LOAD_CHARSET  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_TEMPLATE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD_START    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RESTART       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEXT          = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TEMPLATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_START    = 3'd4;

  // Register reset values
  localparam logic [6:0] CHARSET_SIZE_RST = 7'd26;
  localparam logic [5:0] MIN_LENGTH_RST   = 6'd1;
  localparam logic [5:0] MAX_LENGTH_RST   = 6'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT,
    ST_RDINC,
    ST_UPD,
    ST_FILL,
    ST_MATCH
  } ccg_state_t;

  // Controls broadcast from the sequencer to every cell of the chain
  typedef struct packed {
    logic                 shift;
    logic                 match;
    logic                 upd;
    logic [IDX_W_MAX-1:0] key_idx;
    logic [CHAR_W-1:0]    key_chr;
    logic [LEN_W_MAX-1:0] upd_pos;
    logic [IDX_W_MAX-1:0] upd_idx;
    logic [CHAR_W-1:0]    upd_chr;
    logic [CHAR_W-1:0]    wrap_chr;
    logic [LEN_W_MAX-1:0] len;
  } ccg_bcast_t;

endpackage

`default_nettype wire

[hw/rtl/ccg_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module ccg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/ccg_cell.sv]
// One odometer cell: holds the character and charset index of one candidate position.
// Depends on ccg_pkg for the broadcast control struct.
`default_nettype none

module ccg_cell #(
  parameter int IDX_W    = 6,
  parameter int CELL_POS = 0
) (
  input  wire logic                      clk,
  input  wire ccg_pkg::ccg_bcast_t       bc,
  input  wire logic                      vary,
  input  wire logic [ccg_pkg::CHAR_W-1:0] nb_chr,
  input  wire logic [IDX_W-1:0]          nb_idx,
  output logic      [ccg_pkg::CHAR_W-1:0] chr,
  output logic      [IDX_W-1:0]          idx
);

  import ccg_pkg::*;

  localparam logic [LEN_W_MAX-1:0] MY_POS = LEN_W_MAX'(CELL_POS);

  logic [CHAR_W-1:0] chr_r, chr_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              in_rng;

  assign in_rng = (MY_POS < bc.len);

  // Shift from the right neighbor, latch a charset match, or apply an odometer step
  always_comb begin
    chr_nxt = chr_r;
    idx_nxt = idx_r;
    if (bc.shift) begin
      chr_nxt = nb_chr;
      idx_nxt = nb_idx;
    end else if (bc.match) begin
      if (in_rng && (chr_r == bc.key_chr)) begin
        idx_nxt = bc.key_idx[IDX_W-1:0];
      end
    end else if (bc.upd) begin
      if (MY_POS == bc.upd_pos) begin
        idx_nxt = bc.upd_idx[IDX_W-1:0];
        chr_nxt = bc.upd_chr;
      end else if ((MY_POS > bc.upd_pos) && in_rng && vary) begin
        idx_nxt = '0;
        chr_nxt = bc.wrap_chr;
      end
    end
  end

  always_ff @(posedge clk) begin
    chr_r <= chr_nxt;
    idx_r <= idx_nxt;
  end

  assign chr = chr_r;
  assign idx = idx_r;

endmodule

`default_nettype wire

[hw/rtl/charset_candidate_generator_core.sv]
// Top level of the charset candidate generator: sequencer, config registers and cell chain.
// Depends on ccg_pkg, ccg_ram and ccg_cell.
//
//   channel   handshake              payload
//   in_       start / busy           in_mode, in_char_index, in_position, in_char_value,
//                                    in_wildcard_req
//   out_      out_valid (strobe)     out_char, out_position, out_cand_length,
//                                    out_last_char, out_exhausted
//   cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Loads never raise busy. A next command rotates the whole chain once (one character
// out per cycle for the current length), then steps the odometer in ST_RDINC and, when a
// position can count up, ST_UPD; when the length grows a refill pass (ST_FILL) follows.
// Restart refills the chain in ST_FILL, then sweeps the charset in ST_MATCH when the start
// string is used. A next command after the last candidate answers in the next cycle with
// the exhausted word.
// Reset (rst_n, synchronous) clears the sequencer and config registers and marks
// generation done. Results are strobed for one cycle; the receiver cannot stall them.
`default_nettype none

module charset_candidate_generator_core #(
  parameter int MAX_LEN       = ccg_pkg::DEF_MAX_LEN,
  parameter int CHARSET_DEPTH = ccg_pkg::DEF_CHARSET_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ccg_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [5:0]                    in_char_index,
  input  wire logic [ccg_pkg::POS_W-1:0]     in_position,
  input  wire logic [ccg_pkg::CHAR_W-1:0]    in_char_value,
  input  wire logic                          in_wildcard_req,
  output logic                               out_valid,
  output logic      [ccg_pkg::CHAR_W-1:0]    out_char,
  output logic      [ccg_pkg::POS_W-1:0]     out_position,
  output logic      [ccg_pkg::OUT_LEN_W-1:0] out_cand_length,
  output logic                               out_last_char,
  output logic                               out_exhausted,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ccg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ccg_pkg::CFG_DATA_W-1:0] cfg_data
);

  import ccg_pkg::*;

  localparam int IW      = $clog2(CHARSET_DEPTH);
  localparam int LW      = $clog2(MAX_LEN + 1);
  localparam int SZW     = $clog2(CHARSET_DEPTH + 1);
  localparam int EW      = (SZW > 7) ? SZW : 7;
  localparam int CNT_RAW = $clog2(((MAX_LEN > CHARSET_DEPTH) ? MAX_LEN : CHARSET_DEPTH) + 2);
  localparam int CNT_W   = (CNT_RAW < POS_W) ? POS_W : CNT_RAW;
  localparam int TAW     = $clog2(TBL_DEPTH);

  // Clamp a length register into 1..MAX_LEN
  function automatic logic [LW-1:0] eff_len(input logic [5:0] v);
    logic [LEN_W_MAX-1:0] ext;
    ext = LEN_W_MAX'(v);
    if (v == 6'd0) begin
      return LW'(1);
    end else if (ext > LEN_W_MAX'(MAX_LEN)) begin
      return LW'(MAX_LEN);
    end else begin
      return LW'(ext);
    end
  endfunction

  // Sequencer and bookkeeping
  ccg_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic              from_start_r, from_start_nxt;
  logic              found_r, found_nxt;
  logic [LW-1:0]     pos_inc_r, pos_inc_nxt;
  logic [IW-1:0]     idx_inc_r, idx_inc_nxt;
  logic              fill_v_r, fill_v_nxt;
  logic              fill_rng_r, fill_rng_nxt;
  logic              fill_vary_r, fill_vary_nxt;
  logic              match_v_r, match_v_nxt;
  logic [IW-1:0]     match_k_r, match_k_nxt;

  // Result word
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [OUT_LEN_W-1:0] out_len_r, out_len_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_exh_r, out_exh_nxt;

  // Configuration registers and small tables
  logic [6:0]           cs_r;
  logic [5:0]           min_r;
  logic [5:0]           max_r;
  logic                 ut_r;
  logic                 us_r;
  logic [TBL_DEPTH-1:0] wild_r;
  logic [CHAR_W-1:0]    c0_r;

  // Derived values
  logic              accept;
  logic [EW-1:0]     cs_ext;
  logic [EW-1:0]     eff_sz;
  logic [IW-1:0]     top_idx;
  logic [LW-1:0]     eff_min;
  logic [LW-1:0]     eff_max;
  logic              range_empty;
  logic              vary_at;
  logic              cnt_in_len;
  logic [MAX_LEN-1:0] vary_vec;

  // Memories
  logic              cs_we, tp_we, st_we;
  logic [IW-1:0]     cs_waddr, cs_raddr;
  logic [CHAR_W-1:0] cs_rdata, tp_rdata, st_rdata;
  logic [TAW-1:0]    tbl_raddr;

  // Chain
  ccg_bcast_t        bc;
  logic [CHAR_W-1:0] tail_chr;
  logic [IW-1:0]     tail_idx;
  logic [CHAR_W-1:0] chr_q [MAX_LEN];
  logic [IW-1:0]     idx_q [MAX_LEN];

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign cs_ext      = EW'(cs_r);
  assign eff_sz      = (cs_r == 7'd0) ? EW'(1) :
                       (cs_ext > EW'(CHARSET_DEPTH)) ? EW'(CHARSET_DEPTH) : cs_ext;
  assign top_idx     = IW'(eff_sz - EW'(1));
  assign eff_min     = eff_len(min_r);
  assign eff_max     = eff_len(max_r);
  assign range_empty = (eff_max < eff_min);
  assign vary_at     = !ut_r || wild_r[cnt_r[TAW-1:0]];
  assign cnt_in_len  = (cnt_r < CNT_W'(len_r));
  assign tbl_raddr   = cnt_r[TAW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_RESTART) && !range_empty) begin
          state_nxt = ST_FILL;
        end else if (accept && (in_mode == MODE_NEXT) && !done_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cnt_r == CNT_W'(MAX_LEN - 1)) begin
          state_nxt = ST_RDINC;
        end
      end
      ST_RDINC: begin
        if (found_r) begin
          state_nxt = ST_UPD;
        end else if (len_r >= eff_max) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_FILL;
        end
      end
      ST_UPD: begin
        state_nxt = ST_IDLE;
      end
      ST_FILL: begin
        if (cnt_r == CNT_W'(MAX_LEN)) begin
          state_nxt = from_start_r ? ST_MATCH : ST_IDLE;
        end
      end
      ST_MATCH: begin
        if (cnt_r == CNT_W'(eff_sz)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control per state
  always_comb begin
    cnt_nxt        = ((state_nxt != state_r) || (state_r == ST_IDLE)) ? '0 : cnt_r + CNT_W'(1);
    done_nxt       = done_r;
    len_nxt        = len_r;
    from_start_nxt = from_start_r;
    found_nxt      = found_r;
    pos_inc_nxt    = pos_inc_r;
    idx_inc_nxt    = idx_inc_r;
    fill_v_nxt     = 1'b0;
    fill_rng_nxt   = fill_rng_r;
    fill_vary_nxt  = fill_vary_r;
    match_v_nxt    = 1'b0;
    match_k_nxt    = match_k_r;
    out_valid_nxt  = 1'b0;
    out_char_nxt   = out_char_r;
    out_pos_nxt    = out_pos_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    out_exh_nxt    = out_exh_r;
    cs_raddr       = '0;
    tail_chr       = chr_q[0];
    tail_idx       = idx_q[0];
    bc             = '0;
    bc.len         = LEN_W_MAX'(len_r);
    bc.wrap_chr    = c0_r;
    bc.key_idx     = IDX_W_MAX'(match_k_r);
    bc.key_chr     = cs_rdata;
    bc.upd_pos     = LEN_W_MAX'(pos_inc_r);
    bc.upd_idx     = IDX_W_MAX'(idx_inc_r + IW'(1));
    bc.upd_chr     = cs_rdata;

    unique case (state_r)
      ST_IDLE: begin
        found_nxt = 1'b0;
        if (accept && (in_mode == MODE_RESTART)) begin
          done_nxt = range_empty;
          if (!range_empty) begin
            len_nxt        = eff_min;
            from_start_nxt = us_r;
          end
        end else if (accept && (in_mode == MODE_NEXT) && done_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = '0;
          out_pos_nxt   = '0;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b0;
          out_exh_nxt   = 1'b1;
        end
      end
      ST_EMIT: begin
        // Rotate the chain; the head cell holds position cnt
        bc.shift      = 1'b1;
        out_valid_nxt = cnt_in_len;
        out_char_nxt  = chr_q[0];
        out_pos_nxt   = POS_W'(cnt_r);
        out_len_nxt   = OUT_LEN_W'(len_r);
        out_last_nxt  = ((cnt_r + CNT_W'(1)) == CNT_W'(len_r));
        out_exh_nxt   = 1'b0;
        // Track the rightmost free position that can still count up
        if (cnt_in_len && vary_at && (idx_q[0] < top_idx)) begin
          found_nxt   = 1'b1;
          pos_inc_nxt = LW'(cnt_r);
          idx_inc_nxt = idx_q[0];
        end
      end
      ST_RDINC: begin
        cs_raddr = idx_inc_r + IW'(1);
        if (!found_r) begin
          if (len_r >= eff_max) begin
            done_nxt = 1'b1;
          end else begin
            len_nxt        = len_r + LW'(1);
            from_start_nxt = 1'b0;
          end
        end
      end
      ST_UPD: begin
        bc.upd = 1'b1;
      end
      ST_FILL: begin
        // Read tables at cnt, shift the word for position cnt-1 in at the tail
        fill_v_nxt    = (cnt_r < CNT_W'(MAX_LEN));
        fill_rng_nxt  = cnt_in_len;
        fill_vary_nxt = vary_at;
        bc.shift      = fill_v_r;
        tail_idx      = '0;
        if (!fill_rng_r) begin
          tail_chr = '0;
        end else if (from_start_r) begin
          tail_chr = st_rdata;
        end else if (fill_vary_r) begin
          tail_chr = c0_r;
        end else begin
          tail_chr = tp_rdata;
        end
      end
      ST_MATCH: begin
        // Sweep the charset and let each cell latch the last matching index
        cs_raddr    = IW'(cnt_r);
        match_v_nxt = (cnt_r < CNT_W'(eff_sz));
        match_k_nxt = IW'(cnt_r);
        bc.match    = match_v_r;
      end
      default: begin
      end
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      done_r      <= 1'b1;
      len_r       <= '0;
      found_r     <= 1'b0;
      fill_v_r    <= 1'b0;
      match_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      done_r      <= done_nxt;
      len_r       <= len_nxt;
      found_r     <= found_nxt;
      fill_v_r    <= fill_v_nxt;
      match_v_r   <= match_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold counters and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    from_start_r <= from_start_nxt;
    pos_inc_r    <= pos_inc_nxt;
    idx_inc_r    <= idx_inc_nxt;
    fill_rng_r   <= fill_rng_nxt;
    fill_vary_r  <= fill_vary_nxt;
    match_k_r    <= match_k_nxt;
    out_char_r   <= out_char_nxt;
    out_pos_r    <= out_pos_nxt;
    out_len_r    <= out_len_nxt;
    out_last_r   <= out_last_nxt;
    out_exh_r    <= out_exh_nxt;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r  <= CHARSET_SIZE_RST;
      min_r <= MIN_LENGTH_RST;
      max_r <= MAX_LENGTH_RST;
      ut_r  <= 1'b0;
      us_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHARSET_SIZE: cs_r  <= cfg_data;
        CFG_MIN_LENGTH:   min_r <= cfg_data[5:0];
        CFG_MAX_LENGTH:   max_r <= cfg_data[5:0];
        CFG_USE_TEMPLATE: ut_r  <= cfg_data[0];
        CFG_USE_START:    us_r  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Template wildcard bits and shadow of charset entry zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wild_r <= '1;
    end else if (accept && (in_mode == MODE_LOAD_TEMPLATE)) begin
      wild_r[in_position] <= in_wildcard_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cs_we && (in_char_index == 6'd0)) begin
      c0_r <= in_char_value;
    end
  end

  // Table writes from load words
  assign cs_we    = accept && (in_mode == MODE_LOAD_CHARSET) &&
                    (32'(in_char_index) < CHARSET_DEPTH);
  assign cs_waddr = IW'(in_char_index);
  assign tp_we    = accept && (in_mode == MODE_LOAD_TEMPLATE);
  assign st_we    = accept && (in_mode == MODE_LOAD_START);

  ccg_ram #(.WIDTH(CHAR_W), .DEPTH(CHARSET_DEPTH)) u_charset_ram (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (in_char_value),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  ccg_ram #(.WIDTH(CHAR_W), .DEPTH(TBL_DEPTH)) u_template_ram (
    .clk   (clk),
    .we    (tp_we),
    .waddr (in_position),
    .wdata (in_char_value),
    .raddr (tbl_raddr),
    .rdata (tp_rdata)
  );

  ccg_ram #(.WIDTH(CHAR_W), .DEPTH(TBL_DEPTH)) u_start_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (in_position),
    .wdata (in_char_value),
    .raddr (tbl_raddr),
    .rdata (st_rdata)
  );

  // Row of position cells; each takes its right neighbor, the last takes the tail word
  for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
    assign vary_vec[gi] = !ut_r || wild_r[gi % TBL_DEPTH];
    if (gi == MAX_LEN - 1) begin : g_tail
      ccg_cell #(.IDX_W(IW), .CELL_POS(gi)) u_cell (
        .clk    (clk),
        .bc     (bc),
        .vary   (vary_vec[gi]),
        .nb_chr (tail_chr),
        .nb_idx (tail_idx),
        .chr    (chr_q[gi]),
        .idx    (idx_q[gi])
      );
    end else begin : g_body
      ccg_cell #(.IDX_W(IW), .CELL_POS(gi)) u_cell (
        .clk    (clk),
        .bc     (bc),
        .vary   (vary_vec[gi]),
        .nb_chr (chr_q[gi+1]),
        .nb_idx (idx_q[gi+1]),
        .chr    (chr_q[gi]),
        .idx    (idx_q[gi])
      );
    end
  end

  assign out_valid       = out_valid_r;
  assign out_char        = out_char_r;
  assign out_position    = out_pos_r;
  assign out_cand_length = out_len_r;
  assign out_last_char   = out_last_r;
  assign out_exhausted   = out_exh_r;

endmodule

`default_nettype wire

[tb/sv/ccg_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the charset candidate generator bench: an odometer predictor with its own
// copy of the tables and registers, plus the queue of expected output words. Needs ccg_pkg.
package ccg_tb_pkg;
  import ccg_pkg::*;

  localparam int TBL_CHARS  = DEF_CHARSET_DEPTH;
  localparam int CAND_SLOTS = DEF_MAX_LEN;
  localparam int MAX_PRINTS = 40;

  // Template byte that must come out as a plain fixed character
  localparam logic [CHAR_W-1:0] AT_SIGN = 8'h40;
  // First of the three command codes the block ignores
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_NEXT + 3'd1;

  typedef struct packed {
    logic [CHAR_W-1:0]    chr;
    logic [POS_W-1:0]     pos;
    logic [OUT_LEN_W-1:0] len;
    logic                 last;
    logic                 exhausted;
  } cand_word_t;

  class candidate_board;
    logic [CHAR_W-1:0] charset_tbl [TBL_CHARS];
    logic [CHAR_W-1:0] tmpl_chr    [TBL_DEPTH];
    logic              tmpl_wild   [TBL_DEPTH];
    logic [CHAR_W-1:0] start_tbl   [TBL_DEPTH];
    int unsigned       pos_idx     [CAND_SLOTS];
    logic [CHAR_W-1:0] cand        [CAND_SLOTS];
    int unsigned       cur_len;
    bit                gen_done;

    logic [6:0] reg_size;
    logic [5:0] reg_min;
    logic [5:0] reg_max;
    logic       reg_tmpl;
    logic       reg_start;

    cand_word_t  pending_words[$];
    int unsigned mismatch_count;

    function new();
      foreach (charset_tbl[k]) charset_tbl[k] = '0;
      foreach (tmpl_chr[p]) begin
        tmpl_chr[p]  = '0;
        tmpl_wild[p] = 1'b1;
        start_tbl[p] = '0;
      end
      foreach (cand[p]) begin
        cand[p]    = '0;
        pos_idx[p] = 0;
      end
      cur_len        = 0;
      gen_done       = 1'b1;
      reg_size       = CHARSET_SIZE_RST;
      reg_min        = MIN_LENGTH_RST;
      reg_max        = MAX_LENGTH_RST;
      reg_tmpl       = 1'b0;
      reg_start      = 1'b0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CHARSET_SIZE: reg_size  = data;
        CFG_MIN_LENGTH:   reg_min   = data[5:0];
        CFG_MAX_LENGTH:   reg_max   = data[5:0];
        CFG_USE_TEMPLATE: reg_tmpl  = data[0];
        CFG_USE_START:    reg_start = data[0];
        default: ;
      endcase
    endfunction

    // Charset entries in use, zero read as one and oversize clamped
    function int unsigned span_size();
      if (reg_size == 0) return 1;
      if (reg_size > TBL_CHARS) return TBL_CHARS;
      return reg_size;
    endfunction

    function int unsigned clamp_len(logic [5:0] v);
      if (v == 0) return 1;
      if (v > CAND_SLOTS) return CAND_SLOTS;
      return v;
    endfunction

    function bit is_free(int unsigned p);
      return (reg_tmpl == 1'b0) || (tmpl_wild[p] == 1'b1);
    endfunction

    // Load the first candidate of the current length
    function void load_length(bit from_start);
      int unsigned n;
      n = span_size();
      foreach (cand[p]) begin
        cand[p]    = '0;
        pos_idx[p] = 0;
      end
      for (int unsigned p = 0; p < cur_len && p < CAND_SLOTS; p++) begin
        if (from_start) begin
          cand[p] = start_tbl[p];
          // last matching entry wins; no match leaves index zero
          for (int unsigned k = 0; k < n; k++)
            if (charset_tbl[k] == cand[p]) pos_idx[p] = k;
        end else if (is_free(p)) begin
          cand[p] = charset_tbl[0];
        end else begin
          cand[p] = tmpl_chr[p];
        end
      end
    endfunction

    function bit all_at_top();
      int unsigned top;
      top = span_size() - 1;
      for (int unsigned p = 0; p < cur_len && p < CAND_SLOTS; p++)
        if (is_free(p) && pos_idx[p] < top) return 1'b0;
      return 1'b1;
    endfunction

    // Advance the odometer, rightmost free position fastest
    function void step_odometer();
      int unsigned top;
      top = span_size() - 1;
      if (all_at_top()) begin
        if (cur_len >= clamp_len(reg_max)) begin
          gen_done = 1'b1;
        end else begin
          cur_len++;
          load_length(1'b0);
        end
        return;
      end
      for (int p = int'(cur_len) - 1; p >= 0; p--) begin
        if (is_free(p)) begin
          if (pos_idx[p] < top) begin
            pos_idx[p]++;
            cand[p] = charset_tbl[pos_idx[p] % TBL_CHARS];
            return;
          end
          pos_idx[p] = 0;
          cand[p]    = charset_tbl[0];
        end
      end
    endfunction

    // Apply one accepted command word and queue the words it must produce
    function void note_command(logic [MODE_W-1:0] mode, logic [5:0] cidx,
                               logic [POS_W-1:0] pos, logic [CHAR_W-1:0] val, logic wild);
      cand_word_t w;
      case (mode)
        MODE_LOAD_CHARSET: charset_tbl[cidx] = val;
        MODE_LOAD_TEMPLATE: begin
          tmpl_chr[pos]  = val;
          tmpl_wild[pos] = wild;
        end
        MODE_LOAD_START: start_tbl[pos] = val;
        MODE_RESTART: begin
          if (clamp_len(reg_max) < clamp_len(reg_min)) begin
            gen_done = 1'b1;
          end else begin
            gen_done = 1'b0;
            cur_len  = clamp_len(reg_min);
            load_length(reg_start);
          end
        end
        MODE_NEXT: begin
          if (gen_done) begin
            w = '0;
            w.exhausted = 1'b1;
            pending_words.push_back(w);
          end else begin
            for (int unsigned p = 0; p < cur_len; p++) begin
              w.chr       = cand[p];
              w.pos       = POS_W'(p);
              w.len       = OUT_LEN_W'(cur_len);
              w.last      = (p + 1 == cur_len);
              w.exhausted = 1'b0;
              pending_words.push_back(w);
            end
            step_odometer();
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one output word against the oldest expected word
    task check_word(cand_word_t got);
      cand_word_t want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word char=%h pos=%0d len=%0d last=%b exh=%b",
                                  got.chr, got.pos, got.len, got.last, got.exhausted));
        return;
      end
      want = pending_words.pop_front();
      if (got.chr !== want.chr)
        report_mismatch($sformatf("pos %0d: char %h, want %h", want.pos, got.chr, want.chr));
      if (got.pos !== want.pos)
        report_mismatch($sformatf("position %0d, want %0d", got.pos, want.pos));
      if (got.len !== want.len)
        report_mismatch($sformatf("pos %0d: length %0d, want %0d", want.pos, got.len, want.len));
      if (got.last !== want.last)
        report_mismatch($sformatf("pos %0d: last %b, want %b", want.pos, got.last, want.last));
      if (got.exhausted !== want.exhausted)
        report_mismatch($sformatf("exhausted %b, want %b", got.exhausted, want.exhausted));
    endtask
  endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Top-level bench for charset_candidate_generator_core: drives command words and register
// writes, checks every output word against candidate_board. Needs ccg_pkg and ccg_tb_pkg.
module tb_top;
  import ccg_pkg::*;
  import ccg_tb_pkg::*;

  // Longest quiet stretch of a correct run: restart with start sweep or a length refill
  localparam int SETTLE_CYCLES = 2 * DEF_MAX_LEN + DEF_CHARSET_DEPTH + 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 140;
  localparam int MAX_GAP       = 20;
  localparam int DUP_SRC       = 7;
  localparam int DUP_DST       = 40;

  logic                  clk;
  logic                  rst_n           = 1'b0;
  logic                  start           = 1'b0;
  logic [MODE_W-1:0]     in_mode         = '0;
  logic [5:0]            in_char_index   = '0;
  logic [POS_W-1:0]      in_position     = '0;
  logic [CHAR_W-1:0]     in_char_value   = '0;
  logic                  in_wildcard_req = 1'b0;
  logic                  cfg_valid       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  logic                 busy;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_char;
  logic [POS_W-1:0]     out_position;
  logic [OUT_LEN_W-1:0] out_cand_length;
  logic                 out_last_char;
  logic                 out_exhausted;
  logic                 cfg_ready;

  candidate_board board;
  int unsigned    idle_pct      = 28;
  int unsigned    random_issued = 0;
  int unsigned    stall_cycles  = 0;

  charset_candidate_generator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_char_index   (in_char_index),
    .in_position     (in_position),
    .in_char_value   (in_char_value),
    .in_wildcard_req (in_wildcard_req),
    .out_valid       (out_valid),
    .out_char        (out_char),
    .out_position    (out_position),
    .out_cand_length (out_cand_length),
    .out_last_char   (out_last_char),
    .out_exhausted   (out_exhausted),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Check each strobed output word
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      board.check_word({out_char, out_position, out_cand_length, out_last_char, out_exhausted});
  end

  // End the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one command word; leave start high so a following word can go back to back
  task automatic issue_word(input logic [MODE_W-1:0] mode, input logic [5:0] cidx,
                            input logic [POS_W-1:0] pos, input logic [CHAR_W-1:0] val,
                            input logic wild);
    int unsigned gap;
    gap = 0;
    while (idle_pct != 0 && gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_char_index   <= cidx;
    in_position     <= pos;
    in_char_value   <= val;
    in_wildcard_req <= wild;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_command(mode, cidx, pos, val, wild);
  endtask

  // Restart, next or spare code with a random payload the block should ignore
  task automatic issue_ctrl(input logic [MODE_W-1:0] mode);
    issue_word(mode, 6'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic load_template_entry();
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] chr;
    pos = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4));
    chr = ($urandom_range(0, 3) == 0) ? AT_SIGN : 8'($urandom);
    issue_word(MODE_LOAD_TEMPLATE, 6'($urandom), pos, chr, 1'($urandom));
  endtask

  task automatic load_start_entry();
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] chr;
    pos = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 4));
    chr = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                      : board.charset_tbl[$urandom_range(0, TBL_CHARS - 1)];
    issue_word(MODE_LOAD_START, 6'($urandom), pos, chr, 1'($urandom));
  endtask

  // Drop start and hold until every expected word has come out
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (board.pending_words.size() != 0);
  endtask

  // Write one register; cfg_valid stays high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    board.write_reg(idx, data);
  endtask

  // Reprogram all registers once the block has gone quiet
  task automatic apply_setting(input logic [6:0] size, input logic [5:0] lo,
                               input logic [5:0] hi, input logic tmpl, input logic strt);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(CFG_CHARSET_SIZE, size);
    write_reg(CFG_MIN_LENGTH, {1'b0, lo});
    write_reg(CFG_MAX_LENGTH, {1'b0, hi});
    write_reg(CFG_USE_TEMPLATE, {6'd0, tmpl});
    write_reg(CFG_USE_START, {6'd0, strt});
    cfg_valid <= 1'b0;
  endtask

  // One random setting, a restart, then mostly next words with some noise
  task automatic random_phase();
    logic [6:0]  size;
    logic [5:0]  lo;
    logic [5:0]  hi;
    logic        tmpl;
    logic        strt;
    int unsigned pick;
    case ($urandom_range(0, 9))
      0:          size = 7'd0;
      1:          size = 7'd1;
      2, 3, 4, 5: size = 7'($urandom_range(2, 4));
      6, 7:       size = 7'($urandom_range(5, 63));
      8:          size = 7'd64;
      default:    size = 7'($urandom_range(65, 127));
    endcase
    lo = 6'($urandom_range(1, 3));
    hi = lo + 6'($urandom_range(0, 2));
    case ($urandom_range(0, 11))
      0: begin
        lo = 6'($urandom_range(0, 63));
        hi = 6'($urandom_range(0, 63));
      end
      1:       hi = lo - 6'd1;
      default: ;
    endcase
    tmpl = 1'($urandom);
    strt = 1'($urandom);
    apply_setting(size, lo, hi, tmpl, strt);
    if (tmpl) repeat ($urandom_range(1, 4)) load_template_entry();
    if (strt) repeat ($urandom_range(0, 3)) load_start_entry();
    issue_ctrl(MODE_RESTART);
    repeat ($urandom_range(15, 35)) begin
      idle_pct = (random_issued < 20) ? 28 : (random_issued < 80) ? 50 : 0;
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        issue_ctrl(MODE_NEXT);
      end else if (pick < 84) begin
        issue_word(MODE_LOAD_CHARSET, 6'($urandom), 5'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 88) begin
        load_template_entry();
      end else if (pick < 91) begin
        load_start_entry();
      end else if (pick < 94) begin
        issue_ctrl(MODE_SPARE_LO + 3'($urandom_range(0, 2)));
      end else if (pick < 97) begin
        issue_ctrl(MODE_RESTART);
      end else begin
        wait_drained();
        issue_ctrl(MODE_NEXT);
      end
      random_issued++;
    end
  endtask

  initial begin
    logic [CHAR_W-1:0] val;
    logic [CHAR_W-1:0] foreign;
    bit                hit;

    board = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole charset: 00 and FF at the ends, one duplicated byte
    for (int k = 0; k < TBL_CHARS; k++) begin
      if (k == 0) val = 8'h00;
      else if (k == TBL_CHARS - 1) val = 8'hFF;
      else if (k == DUP_DST) val = board.charset_tbl[DUP_SRC];
      else val = 8'($urandom);
      issue_word(MODE_LOAD_CHARSET, 6'(k), 5'($urandom), val, 1'($urandom));
    end

    // Fill the start string: a duplicated char first, then one absent from the charset
    do begin
      foreign = 8'($urandom);
      hit = 1'b0;
      foreach (board.charset_tbl[k]) if (board.charset_tbl[k] == foreign) hit = 1'b1;
    end while (hit);
    for (int k = 0; k < TBL_DEPTH; k++) begin
      if (k == 0) val = board.charset_tbl[DUP_SRC];
      else if (k == 1) val = foreign;
      else val = board.charset_tbl[$urandom_range(0, TBL_CHARS - 1)];
      issue_word(MODE_LOAD_START, 6'($urandom), 5'(k), val, 1'($urandom));
    end

    // Before any restart a next reports exhaustion
    issue_ctrl(MODE_NEXT);
    // Spare codes: no words, no state change
    issue_ctrl(MODE_SPARE_LO);
    issue_ctrl(MODE_SPARE_LO + 3'd1);
    issue_ctrl(MODE_SPARE_LO + 3'd2);
    // Reset register values
    issue_ctrl(MODE_RESTART);
    issue_ctrl(MODE_NEXT);

    // Two chars, lengths 1..2: six candidates, then exhausted
    apply_setting(7'd2, 6'd1, 6'd2, 1'b0, 1'b0);
    issue_ctrl(MODE_RESTART);
    repeat (7) issue_ctrl(MODE_NEXT);

    // Min above max: restart leaves generation done
    apply_setting(7'd3, 6'd3, 6'd2, 1'b0, 1'b0);
    issue_ctrl(MODE_RESTART);
    issue_ctrl(MODE_NEXT);

    // Zero registers read as one: a single candidate, then exhausted
    apply_setting(7'd0, 6'd0, 6'd0, 1'b0, 1'b0);
    issue_ctrl(MODE_RESTART);
    issue_ctrl(MODE_NEXT);
    issue_ctrl(MODE_NEXT);

    // Oversized registers clamp; full-length start string
    apply_setting(7'd127, 6'd32, 6'd63, 1'b0, 1'b1);
    issue_ctrl(MODE_RESTART);
    issue_ctrl(MODE_NEXT);
    issue_ctrl(MODE_NEXT);

    // Template: fixed '@' first, free middle, fixed 00 third
    apply_setting(7'd3, 6'd2, 6'd3, 1'b1, 1'b0);
    issue_word(MODE_LOAD_TEMPLATE, 6'd0, 5'd0, AT_SIGN, 1'b0);
    issue_word(MODE_LOAD_TEMPLATE, 6'd63, 5'd1, 8'hFF, 1'b1);
    issue_word(MODE_LOAD_TEMPLATE, 6'd0, 5'd2, 8'h00, 1'b0);
    issue_ctrl(MODE_RESTART);
    repeat (3) issue_ctrl(MODE_NEXT);

    while (random_issued < RANDOM_ITEMS) random_phase();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatch_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[charset_candidate_generator_core.f]
hw/rtl/ccg_pkg.sv
hw/rtl/ccg_ram.sv
hw/rtl/ccg_cell.sv
hw/rtl/charset_candidate_generator_core.sv
tb/sv/ccg_tb_pkg.sv
tb/sv/tb_top.sv
